// File: sv/lts_pkg.sv
// ----------------------------------------------------------------------------
// Lottery ticket scheduler package
// Shared constants, operation and status codes, and payload types.
// ----------------------------------------------------------------------------
package lts_pkg;

  // Default sizing of the slot table.
  localparam int NumSlots   = 64;
  localparam int TicketBits = 7;

  // Fixed field widths of the request and response payloads.
  localparam int SlotFieldW = 6;
  localparam int DeltaW     = 8;
  localparam int DrawW      = 32;
  localparam int TixFieldW  = 7;
  localparam int TotalW     = 13;

  // Configuration port.
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 7;

  localparam logic [CfgDataW-1:0] StartTicketsRst = 7'd20;
  localparam logic [CfgDataW-1:0] MaxTicketsRst   = 7'd100;
  localparam logic [CfgDataW-1:0] MinTicketsRst   = 7'd1;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_STOP    = 2'd1,
    OP_NICE    = 2'd2,
    OP_QUANTUM = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_USED = 2'd1,
    ST_IN_USE   = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_TICKETS = 2'd0,
    CFG_MAX_TICKETS   = 2'd1,
    CFG_MIN_TICKETS   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    op_e                      opcode;
    logic [SlotFieldW-1:0]    slot;
    logic signed [DeltaW-1:0] ticket_delta;
    logic [DrawW-1:0]         random_value;
  } in_t;

  typedef struct packed {
    status_e               status;
    logic                  winner_valid;
    logic [SlotFieldW-1:0] winner_slot;
    logic [TixFieldW-1:0]  slot_tickets;
    logic [TotalW-1:0]     ticket_sum;
  } out_t;

endpackage

// File: sv/lts_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lts_ram #(
  parameter int WIDTH = lts_pkg::TicketBits,
  parameter int DEPTH = lts_pkg::NumSlots,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/lottery_ticket_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Lottery ticket scheduler
// Slot table with start, stop, nice and quantum-expired requests; a
// quantum-expired request draws a weighted lottery among holding slots.
// ----------------------------------------------------------------------------
// After reset the block first sweeps the slot flag memory to clear it, one
// slot per cycle, and takes no request until the sweep is done (configuration
// writes are taken at once, always). For start, stop and nice requests the
// slot entry is read during the transfer cycle itself, the execute state
// decides and writes back, and the finish state loads the output register,
// waiting while the previous response has not been taken; the block is then
// ready again. A quantum-expired request on a slot in use spends its time
// between transfer and response on two walks over the slot table through the
// single read port of the table memories (one to sum the tickets, one to find
// the winner) and on a bit-serial remainder unit that spends one cycle per bit
// of the 32-bit random word. The block handles one request at a time; the
// finished response sits in an output register, so the next request may be
// transferred while the previous response still waits on the output side.
// ----------------------------------------------------------------------------
module lottery_ticket_scheduler_unit #(
  parameter int NUM_SLOTS   = lts_pkg::NumSlots,
  parameter int TICKET_BITS = lts_pkg::TicketBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lts_pkg::in_t                 in_data_i,
  // Response channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lts_pkg::out_t                out_data_o,
  // Configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lts_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lts_pkg::CfgDataW-1:0] cfg_data_i
);

  import lts_pkg::*;

  localparam int SlotW = $clog2(NUM_SLOTS);
  localparam int SumW  = TICKET_BITS + SlotW;
  localparam int CntW  = $clog2(DrawW);
  localparam int NiceW = ((TICKET_BITS > DeltaW) ? TICKET_BITS : DeltaW) + 2;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(NUM_SLOTS - 1);
  localparam logic [CntW-1:0]  LastBit  = CntW'(DrawW - 1);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_EXEC   = 7'b0000100,
    S_SUM    = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_WALK   = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_e;

  typedef struct packed {
    logic in_use;
    logic holding;
  } flags_t;

  state_e state_q, state_d;

  // Configuration registers.
  logic [CfgDataW-1:0] start_q, max_q, min_q;

  // Request latched at transfer.
  op_e                      op_q, op_d;
  logic [SlotFieldW-1:0]    slot_q, slot_d;
  logic signed [DeltaW-1:0] delta_q, delta_d;
  logic [DrawW-1:0]         draw_q, draw_d;

  // Sweep control: issued address, issue flag, read-data-valid flag.
  logic [SlotW-1:0] addr_q, addr_d, paddr_q, paddr_d;
  logic             iss_q, iss_d, pv_q, pv_d;

  // Draw arithmetic.
  logic [SumW-1:0] sum_q, sum_d, rem_q, rem_d;
  logic [SumW:0]   rem_shift;
  logic [SumW-1:0] rem_next;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Response fields.
  status_e                status_q, status_d;
  logic                   win_v_q, win_v_d;
  logic [SlotW-1:0]       win_slot_q, win_slot_d;
  logic [TICKET_BITS-1:0] tix_res_q, tix_res_d;

  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  // Memory ports.
  logic                   flg_we, tix_we;
  logic [SlotW-1:0]       flg_waddr, tix_waddr, raddr;
  flags_t                 flg_wdata, flg_rd;
  logic [TICKET_BITS-1:0] tix_wdata, tix_rd;

  // Decode helpers.
  logic                    slot_ok, used, eligible, in_xfer;
  logic [TICKET_BITS-1:0]  start_tix;
  logic signed [NiceW-1:0] nice_sum, nice_max, nice_min, nice_clamp;

  lts_ram #(
    .WIDTH ($bits(flags_t)),
    .DEPTH (NUM_SLOTS)
  ) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flg_we),
    .waddr_i (flg_waddr),
    .wdata_i (flg_wdata),
    .raddr_i (raddr),
    .rdata_o (flg_rd)
  );

  lts_ram #(
    .WIDTH (TICKET_BITS),
    .DEPTH (NUM_SLOTS)
  ) u_tix_ram (
    .clk_i   (clk_i),
    .we_i    (tix_we),
    .waddr_i (tix_waddr),
    .wdata_i (tix_wdata),
    .raddr_i (raddr),
    .rdata_o (tix_rd)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // During an idle cycle the addressed slot is read speculatively, so its
  // entry is ready in the cycle right after the transfer.
  assign raddr = (state_q == S_IDLE) ? SlotW'(in_data_i.slot) : addr_q;

  assign slot_ok   = (32'(slot_q) < 32'(NUM_SLOTS));
  assign used      = slot_ok & flg_rd.in_use;
  assign eligible  = flg_rd.in_use & flg_rd.holding;
  assign start_tix = TICKET_BITS'(start_q);

  // Nice: add the signed delta, clamp to the maximum, then to the minimum,
  // so crossed clamps end up at the minimum.
  always_comb begin
    nice_sum = $signed({{(NiceW - TICKET_BITS){1'b0}}, tix_rd})
             + $signed({{(NiceW - DeltaW){delta_q[DeltaW-1]}}, delta_q});
    nice_max = $signed({{(NiceW - CfgDataW){1'b0}}, max_q});
    nice_min = $signed({{(NiceW - CfgDataW){1'b0}}, min_q});
    nice_clamp = nice_sum;
    if (nice_clamp > nice_max) begin
      nice_clamp = nice_max;
    end
    if (nice_clamp < nice_min) begin
      nice_clamp = nice_min;
    end
  end

  // One restoring step of the remainder: shift in the next dividend bit and
  // subtract the ticket sum when it fits.
  always_comb begin
    rem_shift = {rem_q, draw_q[DrawW-1]};
    if (rem_shift >= {1'b0, sum_q}) begin
      rem_next = SumW'(rem_shift - {1'b0, sum_q});
    end else begin
      rem_next = SumW'(rem_shift);
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    slot_d     = slot_q;
    delta_d    = delta_q;
    draw_d     = draw_q;
    addr_d     = addr_q;
    paddr_d    = paddr_q;
    iss_d      = iss_q;
    pv_d       = pv_q;
    sum_d      = sum_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    status_d   = status_q;
    win_v_d    = win_v_q;
    win_slot_d = win_slot_q;
    tix_res_d  = tix_res_q;
    out_d      = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;

    flg_we    = 1'b0;
    flg_waddr = SlotW'(slot_q);
    flg_wdata = '0;
    tix_we    = 1'b0;
    tix_waddr = SlotW'(slot_q);
    tix_wdata = tix_rd;

    unique case (state_q)
      S_CLEAR: begin
        flg_we    = 1'b1;
        flg_waddr = addr_q;
        if (addr_q == LastSlot) begin
          addr_d  = '0;
          state_d = S_IDLE;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_xfer) begin
          op_d       = in_data_i.opcode;
          slot_d     = in_data_i.slot;
          delta_d    = in_data_i.ticket_delta;
          draw_d     = in_data_i.random_value;
          sum_d      = '0;
          win_v_d    = 1'b0;
          win_slot_d = '0;
          status_d   = ST_OK;
          tix_res_d  = '0;
          state_d    = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_FINISH;
        if (op_q == OP_START) begin
          if (!slot_ok) begin
            status_d = ST_NOT_USED;
          end else if (used) begin
            status_d  = ST_IN_USE;
            tix_res_d = tix_rd;
          end else begin
            flg_we    = 1'b1;
            flg_wdata = '{in_use: 1'b1, holding: 1'b1};
            tix_we    = 1'b1;
            tix_wdata = start_tix;
            tix_res_d = start_tix;
          end
        end else if (!used) begin
          status_d = ST_NOT_USED;
        end else begin
          unique case (op_q)
            OP_STOP: begin
              flg_we    = 1'b1;
              flg_wdata = '{in_use: 1'b0, holding: 1'b0};
            end
            OP_NICE: begin
              tix_we    = 1'b1;
              tix_wdata = TICKET_BITS'(nice_clamp);
              tix_res_d = TICKET_BITS'(nice_clamp);
            end
            OP_QUANTUM: begin
              // Back into holding before the tickets are summed.
              flg_we    = 1'b1;
              flg_wdata = '{in_use: 1'b1, holding: 1'b1};
              tix_res_d = tix_rd;
              addr_d    = '0;
              iss_d     = 1'b1;
              pv_d      = 1'b0;
              state_d   = S_SUM;
            end
            default: begin
              state_d = S_FINISH;
            end
          endcase
        end
      end

      S_SUM: begin
        pv_d    = iss_q;
        paddr_d = addr_q;
        if (iss_q) begin
          if (addr_q == LastSlot) begin
            iss_d = 1'b0;
          end else begin
            addr_d = addr_q + 1'b1;
          end
        end
        if (pv_q && eligible) begin
          sum_d = sum_q + SumW'(tix_rd);
        end
        if (pv_q && !iss_q) begin
          // Last entry is in; a zero sum means nobody can win.
          if (sum_d == '0) begin
            state_d = S_FINISH;
          end else begin
            rem_d   = '0;
            cnt_d   = '0;
            state_d = S_DIV;
          end
        end
      end

      S_DIV: begin
        rem_d  = rem_next;
        draw_d = draw_q << 1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == LastBit) begin
          // Winning ticket number, counted from one.
          rem_d   = rem_next + 1'b1;
          addr_d  = '0;
          iss_d   = 1'b1;
          pv_d    = 1'b0;
          state_d = S_WALK;
        end
      end

      S_WALK: begin
        pv_d    = iss_q;
        paddr_d = addr_q;
        if (iss_q) begin
          if (addr_q == LastSlot) begin
            iss_d = 1'b0;
          end else begin
            addr_d = addr_q + 1'b1;
          end
        end
        if (pv_q && eligible && (rem_q <= SumW'(tix_rd))) begin
          flg_we     = 1'b1;
          flg_waddr  = paddr_q;
          flg_wdata  = '{in_use: 1'b1, holding: 1'b0};
          win_v_d    = 1'b1;
          win_slot_d = paddr_q;
          iss_d      = 1'b0;
          state_d    = S_FINISH;
        end else begin
          if (pv_q && eligible) begin
            rem_d = rem_q - SumW'(tix_rd);
          end
          if (pv_q && !iss_q) begin
            state_d = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d        = 1'b1;
          out_d.status       = status_q;
          out_d.winner_valid = win_v_q;
          out_d.winner_slot  = SlotFieldW'(win_slot_q);
          out_d.slot_tickets = TixFieldW'(tix_res_q);
          out_d.ticket_sum   = TotalW'(sum_q);
          state_d            = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      addr_q      <= '0;
      iss_q       <= 1'b0;
      pv_q        <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      start_q     <= StartTicketsRst;
      max_q       <= MaxTicketsRst;
      min_q       <= MinTicketsRst;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      iss_q       <= iss_d;
      pv_q        <= pv_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_START_TICKETS: start_q <= cfg_data_i;
          CFG_MAX_TICKETS:   max_q   <= cfg_data_i;
          CFG_MIN_TICKETS:   min_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    slot_q     <= slot_d;
    delta_q    <= delta_d;
    draw_q     <= draw_d;
    paddr_q    <= paddr_d;
    sum_q      <= sum_d;
    rem_q      <= rem_d;
    status_q   <= status_d;
    win_v_q    <= win_v_d;
    win_slot_q <= win_slot_d;
    tix_res_q  <= tix_res_d;
    out_q      <= out_d;
  end

endmodule

// File: sv/lts_checker.sv
// ----------------------------------------------------------------------------
// Lottery ticket scheduler checker
// Port-level properties of the scheduler, attached to the top level by bind.
// ----------------------------------------------------------------------------
module lts_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input lts_pkg::out_t out_data_o
);

  import lts_pkg::*;

  // One request at a time: a transfer closes the request side.
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request side still open after a transfer");

  // A winner only comes out of a successful draw.
  a_winner_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.winner_valid |-> out_data_o.status == ST_OK)
    else $error("winner reported on a failed request");

  // A refused request draws nothing.
  a_refused_no_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |->
      !out_data_o.winner_valid && (out_data_o.ticket_sum == '0))
    else $error("refused request shows draw results");

  // Without a winner the winner slot reads zero.
  a_no_winner_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.winner_valid |-> out_data_o.winner_slot == '0)
    else $error("winner slot set without a winner");

  // A stalled response holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled response changed");

endmodule

bind lottery_ticket_scheduler_unit lts_checker u_lts_checker (.*);

// File: tb/lts_response_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lottery ticket scheduler response checker
// Watches the request, response and configuration channels, keeps its own
// copy of the slot table, predicts each response and compares it field by
// field with what the block returns.
// ----------------------------------------------------------------------------
module lts_response_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  lts_pkg::in_t                 in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  lts_pkg::out_t                out_data_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [lts_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lts_pkg::CfgDataW-1:0] cfg_data_i,
  output int unsigned                  fail_cnt_o,
  output int unsigned                  pending_o
);

  import lts_pkg::*;

  logic [CfgDataW-1:0]  start_tix_q;
  logic [CfgDataW-1:0]  max_tix_q;
  logic [CfgDataW-1:0]  min_tix_q;
  bit                   in_use_q  [NumSlots];
  bit                   waiting_q [NumSlots];
  logic [TixFieldW-1:0] tix_q     [NumSlots];

  out_t        expected_responses [$];
  int unsigned fail_cnt = 0;
  int unsigned pending  = 0;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = pending;

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    fail_cnt++;
    $display("%0t ns: mismatch on %s, got %0d, expected %0d", $time, what, got, want);
  endtask

  // Applies one request to the slot table copy and returns the response it causes.
  function automatic out_t schedule_step(in_t req);
    out_t        rsp;
    int unsigned s;
    int unsigned i;
    int          v;
    int unsigned sum;
    int unsigned left;
    bit          known;
    rsp   = '0;
    sum   = 0;
    s     = req.slot;
    known = (s < NumSlots) && in_use_q[s];
    if (req.opcode == OP_START) begin
      if (s >= NumSlots) begin
        rsp.status = ST_NOT_USED;
      end else if (known) begin
        rsp.status = ST_IN_USE;
      end else begin
        in_use_q[s]  = 1'b1;
        waiting_q[s] = 1'b1;
        tix_q[s]     = start_tix_q;
      end
    end else if (!known) begin
      rsp.status = ST_NOT_USED;
    end else if (req.opcode == OP_STOP) begin
      in_use_q[s]  = 1'b0;
      waiting_q[s] = 1'b0;
    end else if (req.opcode == OP_NICE) begin
      // The upper clamp goes first, so crossed clamps end at the lower one.
      v = int'(tix_q[s]) + int'($signed(req.ticket_delta));
      if (v > int'(max_tix_q)) v = int'(max_tix_q);
      if (v < int'(min_tix_q)) v = int'(min_tix_q);
      tix_q[s] = v[TixFieldW-1:0];
    end else begin
      waiting_q[s] = 1'b1;
      for (i = 0; i < NumSlots; i++) begin
        if (in_use_q[i] && waiting_q[i]) sum += tix_q[i];
      end
      if (sum != 0) begin
        left = req.random_value % sum + 1;
        for (i = 0; i < NumSlots; i++) begin
          if (in_use_q[i] && waiting_q[i] && !rsp.winner_valid) begin
            if (left <= tix_q[i]) begin
              waiting_q[i]     = 1'b0;
              rsp.winner_valid = 1'b1;
              rsp.winner_slot  = i[SlotFieldW-1:0];
            end else begin
              left -= tix_q[i];
            end
          end
        end
      end
      rsp.ticket_sum = sum[TotalW-1:0];
    end
    if (s < NumSlots && in_use_q[s]) rsp.slot_tickets = tix_q[s];
    return rsp;
  endfunction

  task automatic check_response(out_t got);
    out_t want;
    if (expected_responses.size() == 0) begin
      report_mismatch("response with no request outstanding", got, 0);
      return;
    end
    want = expected_responses.pop_front();
    if (got.status != want.status) report_mismatch("status", got.status, want.status);
    if (got.winner_valid != want.winner_valid) begin
      report_mismatch("winner_valid", got.winner_valid, want.winner_valid);
    end
    if (got.winner_slot != want.winner_slot) begin
      report_mismatch("winner_slot", got.winner_slot, want.winner_slot);
    end
    if (got.slot_tickets != want.slot_tickets) begin
      report_mismatch("slot_tickets", got.slot_tickets, want.slot_tickets);
    end
    if (got.ticket_sum != want.ticket_sum) begin
      report_mismatch("ticket_sum", got.ticket_sum, want.ticket_sum);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_tix_q = StartTicketsRst;
      max_tix_q   = MaxTicketsRst;
      min_tix_q   = MinTicketsRst;
      for (int i = 0; i < NumSlots; i++) begin
        in_use_q[i]  = 1'b0;
        waiting_q[i] = 1'b0;
        tix_q[i]     = '0;
      end
      expected_responses.delete();
      pending <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_START_TICKETS: start_tix_q = cfg_data_i;
          CFG_MAX_TICKETS:   max_tix_q   = cfg_data_i;
          CFG_MIN_TICKETS:   min_tix_q   = cfg_data_i;
          default: ;
        endcase
      end
      // The response side is checked first: a response at this edge always
      // belongs to an older request than one taken at the same edge.
      if (out_valid_i && out_ready_i) check_response(out_data_i);
      if (in_valid_i && in_ready_i) expected_responses.push_back(schedule_step(in_data_i));
      pending <= expected_responses.size();
    end
  end

endmodule

// File: tb/lottery_ticket_scheduler_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lottery ticket scheduler testbench
// Drives directed and random scheduler requests and register writes into the
// block, stalls both channels at random, and leaves prediction and comparison
// of every response to the checker beside the block.
// ----------------------------------------------------------------------------
module lottery_ticket_scheduler_unit_test;
  import lts_pkg::*;

  // The random part runs in phases; each phase uses its own register setting.
  localparam int NumPhases     = 6;
  localparam int ItemsPerPhase = 250;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_t                 in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;
  int unsigned         fail_cnt;
  int unsigned         pending;

  // When this is low, neither side inserts bubbles.
  bit idle_en = 1'b1;

  // Slots this testbench has started and not yet stopped. It only steers the
  // random requests toward useful slots; it plays no part in the checking.
  bit live [NumSlots];

  always #5 clk = ~clk;

  lottery_ticket_scheduler_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  lts_response_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  // The response side stalls in about 38 percent of cycles unless bubbles are
  // switched off.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !idle_en || ($urandom_range(99) >= 38);
    end
  end

  function automatic in_t make_req(op_e op, int s, int d, logic [DrawW-1:0] rnd);
    in_t r;
    r              = '0;
    r.opcode       = op;
    r.slot         = s[SlotFieldW-1:0];
    r.ticket_delta = d[DeltaW-1:0];
    r.random_value = rnd;
    return r;
  endfunction

  // Random requests are mostly well formed: starts go to free slots, and
  // stop, nice and quantum-expired go to live ones. The rest are aimed
  // anywhere, which gives the in-use and not-in-use answers.
  function automatic in_t random_req();
    in_t r;
    int  pick;
    int  s;
    int  n;
    bit  want_live;
    r    = '0;
    pick = $urandom_range(99);
    if (pick < 30) r.opcode = OP_START;
    else if (pick < 45) r.opcode = OP_STOP;
    else if (pick < 70) r.opcode = OP_NICE;
    else r.opcode = OP_QUANTUM;
    s = $urandom_range(NumSlots - 1);
    if ($urandom_range(99) < 85) begin
      want_live = (r.opcode != OP_START);
      for (n = 0; n < NumSlots && live[s] != want_live; n++) s = (s + 1) % NumSlots;
    end
    r.slot = s[SlotFieldW-1:0];
    if ($urandom_range(1) == 0) r.ticket_delta = DeltaW'($urandom_range(20) - 10);
    else r.ticket_delta = DeltaW'($urandom_range(255));
    pick = $urandom_range(9);
    if (pick == 0) r.random_value = '0;
    else if (pick == 1) r.random_value = '1;
    else r.random_value = $urandom;
    return r;
  endfunction

  // Presents one request and returns at the edge where it is transferred.
  // Valid stays high afterwards, so back-to-back requests need no toggle.
  task automatic request(in_t req);
    if (idle_en && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 38);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    if (req.opcode == OP_START) live[req.slot] = 1'b1;
    else if (req.opcode == OP_STOP) live[req.slot] = 1'b0;
  endtask

  // Drops valid and waits until every response has come back. The first edge
  // lets the checker count the request transferred at the current edge.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Only called while the block is idle.
  task automatic set_tickets(int start_t, int max_t, int min_t);
    write_reg(CFG_START_TICKETS, start_t[CfgDataW-1:0]);
    write_reg(CFG_MAX_TICKETS, max_t[CfgDataW-1:0]);
    write_reg(CFG_MIN_TICKETS, min_t[CfgDataW-1:0]);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset register values first. Requests on a free slot
    // must be refused and leave the table alone.
    request(make_req(OP_QUANTUM, 5, 0, 0));
    request(make_req(OP_STOP, 5, 0, 0));
    request(make_req(OP_NICE, 5, 1, 0));
    // A second start on a used slot is refused.
    request(make_req(OP_START, 0, 0, 0));
    request(make_req(OP_START, 0, 0, 0));
    request(make_req(OP_START, NumSlots - 1, 0, 0));
    // The largest and smallest deltas run into both clamps.
    request(make_req(OP_NICE, 0, 127, 0));
    request(make_req(OP_NICE, 0, -128, 0));
    request(make_req(OP_NICE, NumSlots - 1, 5, 0));
    // Draws with the smallest and largest random words.
    request(make_req(OP_QUANTUM, 0, 0, 32'h0000_0000));
    request(make_req(OP_QUANTUM, NumSlots - 1, 0, 32'hFFFF_FFFF));
    request(make_req(OP_STOP, NumSlots - 1, 0, 0));
    request(make_req(OP_QUANTUM, 0, 0, 32'd12345));
    request(make_req(OP_STOP, 0, 0, 0));
    drain();

    // Crossed clamps: the lower clamp is above the upper one and wins.
    set_tickets(20, 10, 90);
    request(make_req(OP_START, 1, 0, 0));
    request(make_req(OP_NICE, 1, -3, 0));
    request(make_req(OP_NICE, 1, 127, 0));
    request(make_req(OP_QUANTUM, 1, 0, 32'hDEAD_BEEF));
    request(make_req(OP_STOP, 1, 0, 0));
    drain();

    // Zero starting tickets: a draw over nothing but empty slots finds no
    // winner, and a zero lower clamp lets a nice reach zero.
    set_tickets(0, 127, 0);
    request(make_req(OP_START, 2, 0, 0));
    request(make_req(OP_START, 3, 0, 0));
    request(make_req(OP_QUANTUM, 2, 0, 32'h1234_5678));
    request(make_req(OP_NICE, 3, -128, 0));
    request(make_req(OP_NICE, 3, 127, 0));
    request(make_req(OP_STOP, 2, 0, 0));
    request(make_req(OP_STOP, 3, 0, 0));
    drain();

    // Random part. The slot table carries over from phase to phase, so later
    // phases see a table filled under earlier settings.
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: set_tickets(20, 100, 1);
        1: set_tickets(127, 127, 1);
        2: set_tickets(1, 127, 127);
        4: set_tickets(127, 0, 0);
        default: set_tickets($urandom_range(127), $urandom_range(127), $urandom_range(127));
      endcase
      // One phase runs with no bubbles on either side.
      idle_en = (p != 3);
      for (int n = 0; n < ItemsPerPhase; n++) request(random_req());
      drain();
    end
    idle_en = 1'b1;

    // Before the verdict, wait long enough for a draw to finish, so anything still
    // in flight shows up as a stray response.
    repeat (200) @(posedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond a run where every request is a full draw and both
  // sides stall at their worst.
  initial begin
    #15_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
